>>> sv/sjv_pkg.sv
// ----------------------------------------------------------------------------
// sjv_pkg: shared types and helpers of the strict JSON stream validator
// Event codes, scanner states, the scanner state record and small lookups.
// ----------------------------------------------------------------------------
package sjv_pkg;

    localparam int MaxDepth = 16;
    localparam int StackDepth = MaxDepth + 1;
    localparam int StackAw = $clog2(StackDepth);
    localparam int MaxEv = 5;
    localparam logic [15:0] NodeLimitReset = 16'd4096;

    typedef enum logic [3:0] {
        K_OBJ_OPEN, K_OBJ_CLOSE, K_ARR_OPEN, K_ARR_CLOSE, K_STR_OPEN, K_STR_BYTE,
        K_STR_CLOSE, K_NUM_CHAR, K_NUM_END, K_TRUE, K_FALSE, K_NULL, K_DOC_END
    } t_kind;

    typedef enum logic [4:0] {
        LEX_DOC, LEX_ARR_FIRST, LEX_ELEM, LEX_MEMBER, LEX_KEY_FIRST, LEX_KEY_NEXT,
        LEX_COLON, LEX_AFTER, LEX_STR, LEX_ESC, LEX_HEX, LEX_SBS, LEX_SU, LEX_HEXL,
        LEX_TRUE, LEX_FALSE, LEX_NULL,
        LEX_NSIGN, LEX_NZERO, LEX_NINT, LEX_NDOT, LEX_NFRAC, LEX_NE, LEX_NESIGN,
        LEX_NEXP
    } t_lex;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic        nm;
        logic [4:0]  lvl;
        logic        ok;
    } t_ev;

    typedef struct packed {
        t_lex        lex;
        logic        nm;
        logic [4:0]  nest;
        logic [15:0] nodes;
        logic [15:0] hex;
        logic [9:0]  hs;
        logic [2:0]  lpos;
        logic        failed;
    } t_st;

    typedef struct packed {
        logic en;
        logic arr;
    } t_stk_wr;

    function automatic t_ev mk_ev(t_kind kind, logic [7:0] data, logic nm,
                                  logic [4:0] lvl, logic ok);
        t_ev e;
        e.kind = kind;
        e.data = data;
        e.nm = nm;
        e.lvl = lvl;
        e.ok = ok;
        return e;
    endfunction

    // Returns 16 for a byte that is not a hex digit.
    function automatic logic [4:0] hex_nib(logic [7:0] b);
        logic [4:0] r;
        r = 5'd16;
        if (b >= "0" && b <= "9") begin
            r = {1'b0, b[3:0]};
        end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
            r = {1'b0, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic [2:0] lit_len(t_lex w);
        return (w == LEX_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic [7:0] lit_char(t_lex w, logic [2:0] pos);
        logic [7:0] r;
        r = 8'h00;
        case (w)
            LEX_TRUE: begin
                case (pos)
                    3'd0: r = "t";
                    3'd1: r = "r";
                    3'd2: r = "u";
                    3'd3: r = "e";
                    default: r = 8'h00;
                endcase
            end
            LEX_FALSE: begin
                case (pos)
                    3'd0: r = "f";
                    3'd1: r = "a";
                    3'd2: r = "l";
                    3'd3: r = "s";
                    3'd4: r = "e";
                    default: r = 8'h00;
                endcase
            end
            default: begin
                case (pos)
                    3'd0: r = "n";
                    3'd1: r = "u";
                    3'd2: r = "l";
                    3'd3: r = "l";
                    default: r = 8'h00;
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic t_kind lit_kind(t_lex w);
        t_kind k;
        case (w)
            LEX_TRUE: k = K_TRUE;
            LEX_FALSE: k = K_FALSE;
            default: k = K_NULL;
        endcase
        return k;
    endfunction

endpackage

>>> sv/sjv_step.sv
// ----------------------------------------------------------------------------
// sjv_step: one-byte scanner step
// From the scanner state and one byte, works out the next state, the stack
// write and the list of events that the byte causes.
// ----------------------------------------------------------------------------
module sjv_step (
    input  sjv_pkg::t_st     i_st,
    input  logic [7:0]       i_byte,
    input  logic             i_final,
    input  logic [15:0]      i_limit,
    input  logic             i_top_arr,
    output sjv_pkg::t_st     o_st,
    output sjv_pkg::t_ev     o_ev [sjv_pkg::MaxEv],
    output logic [2:0]       o_cnt,
    output sjv_pkg::t_stk_wr o_wr
);
    import sjv_pkg::*;

    always_comb begin
        t_st        s;
        t_ev        ev [MaxEv];
        logic [2:0] c;
        t_stk_wr    wr;
        logic       go_b;
        logic       u_en;
        logic [20:0] cp;
        logic [4:0] lname;
        logic [4:0] lstr;
        logic [7:0] b;
        logic       ws;
        logic       dig;
        logic       e_ch;
        logic       nend;
        t_lex       nxt;
        logic [4:0] nib;
        logic [15:0] hx;
        logic [7:0] esc;
        logic       esc_ok;
        logic       vld;

        s = i_st;
        c = 3'd0;
        for (int k = 0; k < MaxEv; k++) begin
            ev[k] = '0;
        end
        wr = '0;
        u_en = 1'b0;
        cp = '0;
        b = i_byte;
        ws = (b == " ") || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
        dig = (b >= "0") && (b <= "9");
        e_ch = (b == "e") || (b == "E");
        lname = (s.nest == 5'd0) ? 5'd0 : s.nest - 5'd1;
        lstr = s.nm ? lname : s.nest;
        go_b = !s.failed;
        nend = 1'b0;
        nxt = s.lex;
        nib = hex_nib(b);
        hx = {s.hex[11:0], nib[3:0]};
        esc = 8'h00;
        esc_ok = 1'b1;
        vld = 1'b0;

        // Number bytes; a byte that ends a number is scanned again as AFTER.
        if (!s.failed && s.lex >= LEX_NSIGN) begin
            go_b = 1'b0;
            case (s.lex)
                LEX_NSIGN: begin
                    if (!dig) s.failed = 1'b1;
                    else nxt = (b == "0") ? LEX_NZERO : LEX_NINT;
                end
                LEX_NZERO: begin
                    if (dig) s.failed = 1'b1;
                    else if (b == ".") nxt = LEX_NDOT;
                    else if (e_ch) nxt = LEX_NE;
                    else nend = 1'b1;
                end
                LEX_NINT: begin
                    if (dig) nxt = LEX_NINT;
                    else if (b == ".") nxt = LEX_NDOT;
                    else if (e_ch) nxt = LEX_NE;
                    else nend = 1'b1;
                end
                LEX_NDOT: begin
                    if (dig) nxt = LEX_NFRAC;
                    else s.failed = 1'b1;
                end
                LEX_NFRAC: begin
                    if (dig) nxt = LEX_NFRAC;
                    else if (e_ch) nxt = LEX_NE;
                    else nend = 1'b1;
                end
                LEX_NE: begin
                    if (b == "+" || b == "-") nxt = LEX_NESIGN;
                    else if (dig) nxt = LEX_NEXP;
                    else s.failed = 1'b1;
                end
                LEX_NESIGN: begin
                    if (dig) nxt = LEX_NEXP;
                    else s.failed = 1'b1;
                end
                default: begin
                    if (dig) nxt = LEX_NEXP;
                    else nend = 1'b1;
                end
            endcase
            if (!s.failed) begin
                if (nend) begin
                    ev[c] = mk_ev(K_NUM_END, 8'h00, 1'b0, s.nest, 1'b0);
                    c = c + 3'd1;
                    s.lex = LEX_AFTER;
                    go_b = 1'b1;
                end else begin
                    ev[c] = mk_ev(K_NUM_CHAR, b, 1'b0, s.nest, 1'b0);
                    c = c + 3'd1;
                    s.lex = nxt;
                end
            end
        end

        if (go_b) begin
            case (s.lex)
                LEX_DOC, LEX_ARR_FIRST, LEX_ELEM, LEX_MEMBER: begin
                    if (ws) begin
                        s.lex = s.lex;
                    end else if (s.lex == LEX_ARR_FIRST && b == "]") begin
                        s.nest = s.nest - 5'd1;
                        ev[c] = mk_ev(K_ARR_CLOSE, 8'h00, 1'b0, s.nest, 1'b0);
                        c = c + 3'd1;
                        s.lex = LEX_AFTER;
                    end else if (s.nest > 5'(MaxDepth) || s.nodes >= i_limit) begin
                        s.failed = 1'b1;
                    end else begin
                        s.nodes = s.nodes + 16'd1;
                        if (b == "{" || b == "[") begin
                            wr.en = 1'b1;
                            wr.arr = (b == "[");
                            ev[c] = mk_ev((b == "[") ? K_ARR_OPEN : K_OBJ_OPEN, 8'h00,
                                          1'b0, s.nest, 1'b0);
                            c = c + 3'd1;
                            s.nest = s.nest + 5'd1;
                            s.lex = (b == "[") ? LEX_ARR_FIRST : LEX_KEY_FIRST;
                        end else if (b == "\"") begin
                            ev[c] = mk_ev(K_STR_OPEN, 8'h00, 1'b0, s.nest, 1'b0);
                            c = c + 3'd1;
                            s.lex = LEX_STR;
                            s.nm = 1'b0;
                        end else if (b == "t" || b == "f" || b == "n") begin
                            s.lpos = 3'd1;
                            s.lex = (b == "t") ? LEX_TRUE :
                                    (b == "f") ? LEX_FALSE : LEX_NULL;
                        end else if (b == "-" || dig) begin
                            ev[c] = mk_ev(K_NUM_CHAR, b, 1'b0, s.nest, 1'b0);
                            c = c + 3'd1;
                            s.lex = (b == "-") ? LEX_NSIGN :
                                    (b == "0") ? LEX_NZERO : LEX_NINT;
                        end else begin
                            s.failed = 1'b1;
                        end
                    end
                end
                LEX_KEY_FIRST, LEX_KEY_NEXT: begin
                    if (ws) begin
                        s.lex = s.lex;
                    end else if (s.lex == LEX_KEY_FIRST && b == "}") begin
                        s.nest = s.nest - 5'd1;
                        ev[c] = mk_ev(K_OBJ_CLOSE, 8'h00, 1'b0, s.nest, 1'b0);
                        c = c + 3'd1;
                        s.lex = LEX_AFTER;
                    end else if (b == "\"") begin
                        ev[c] = mk_ev(K_STR_OPEN, 8'h00, 1'b1, lname, 1'b0);
                        c = c + 3'd1;
                        s.lex = LEX_STR;
                        s.nm = 1'b1;
                    end else begin
                        s.failed = 1'b1;
                    end
                end
                LEX_COLON: begin
                    if (ws) s.lex = s.lex;
                    else if (b == ":") s.lex = LEX_MEMBER;
                    else s.failed = 1'b1;
                end
                LEX_AFTER: begin
                    if (ws) begin
                        s.lex = s.lex;
                    end else if (s.nest == 5'd0 || s.nest > 5'(StackDepth)) begin
                        s.failed = 1'b1;
                    end else if (b == ",") begin
                        s.lex = i_top_arr ? LEX_ELEM : LEX_KEY_NEXT;
                    end else if ((i_top_arr && b == "]") || (!i_top_arr && b == "}")) begin
                        s.nest = s.nest - 5'd1;
                        ev[c] = mk_ev(i_top_arr ? K_ARR_CLOSE : K_OBJ_CLOSE, 8'h00,
                                      1'b0, s.nest, 1'b0);
                        c = c + 3'd1;
                        s.lex = LEX_AFTER;
                    end else begin
                        s.failed = 1'b1;
                    end
                end
                LEX_STR: begin
                    if (b == "\"") begin
                        ev[c] = mk_ev(K_STR_CLOSE, 8'h00, s.nm, lstr, 1'b0);
                        c = c + 3'd1;
                        s.lex = s.nm ? LEX_COLON : LEX_AFTER;
                        s.nm = 1'b0;
                    end else if (b < 8'h20) begin
                        s.failed = 1'b1;
                    end else if (b == "\\") begin
                        s.lex = LEX_ESC;
                    end else begin
                        ev[c] = mk_ev(K_STR_BYTE, b, s.nm, lstr, 1'b0);
                        c = c + 3'd1;
                    end
                end
                LEX_ESC: begin
                    case (b)
                        "\"", "\\", "/": esc = b;
                        "b": esc = 8'h08;
                        "f": esc = 8'h0C;
                        "n": esc = 8'h0A;
                        "r": esc = 8'h0D;
                        "t": esc = 8'h09;
                        default: esc_ok = 1'b0;
                    endcase
                    if (b == "u") begin
                        s.hex = '0;
                        s.lpos = 3'd0;
                        s.lex = LEX_HEX;
                    end else if (esc_ok) begin
                        ev[c] = mk_ev(K_STR_BYTE, esc, s.nm, lstr, 1'b0);
                        c = c + 3'd1;
                        s.lex = LEX_STR;
                    end else begin
                        s.failed = 1'b1;
                    end
                end
                LEX_HEX, LEX_HEXL: begin
                    if (nib[4]) begin
                        s.failed = 1'b1;
                    end else begin
                        s.hex = hx;
                        if (s.lpos < 3'd3) begin
                            s.lpos = s.lpos + 3'd1;
                        end else begin
                            s.lpos = 3'd0;
                            if (s.lex == LEX_HEX) begin
                                if (hx >= 16'hD800 && hx <= 16'hDBFF) begin
                                    s.hs = hx[9:0];
                                    s.lex = LEX_SBS;
                                end else if (hx >= 16'hDC00) begin
                                    if (hx <= 16'hDFFF) begin
                                        s.failed = 1'b1;
                                    end else begin
                                        u_en = 1'b1;
                                        cp = {5'd0, hx};
                                        s.lex = LEX_STR;
                                    end
                                end else begin
                                    u_en = 1'b1;
                                    cp = {5'd0, hx};
                                    s.lex = LEX_STR;
                                end
                            end else if (hx < 16'hDC00 || hx > 16'hDFFF) begin
                                s.failed = 1'b1;
                            end else begin
                                u_en = 1'b1;
                                cp = 21'h10000 + {1'b0, s.hs, hx[9:0]};
                                s.lex = LEX_STR;
                            end
                        end
                    end
                end
                LEX_SBS: begin
                    if (b == "\\") s.lex = LEX_SU;
                    else s.failed = 1'b1;
                end
                LEX_SU: begin
                    if (b == "u") begin
                        s.hex = '0;
                        s.lpos = 3'd0;
                        s.lex = LEX_HEXL;
                    end else begin
                        s.failed = 1'b1;
                    end
                end
                LEX_TRUE, LEX_FALSE, LEX_NULL: begin
                    if (s.lpos >= lit_len(s.lex) || b != lit_char(s.lex, s.lpos)) begin
                        s.failed = 1'b1;
                    end else begin
                        s.lpos = s.lpos + 3'd1;
                        if (s.lpos == lit_len(s.lex)) begin
                            s.lpos = 3'd0;
                            ev[c] = mk_ev(lit_kind(s.lex), 8'h00, 1'b0, s.nest, 1'b0);
                            c = c + 3'd1;
                            s.lex = LEX_AFTER;
                        end
                    end
                end
                default: begin
                    s.failed = 1'b1;
                end
            endcase
        end

        // UTF-8 encoding of a decoded \u escape.
        if (u_en) begin
            if (cp <= 21'h7F) begin
                ev[c] = mk_ev(K_STR_BYTE, cp[7:0], s.nm, lstr, 1'b0);
                c = c + 3'd1;
            end else if (cp <= 21'h7FF) begin
                ev[c] = mk_ev(K_STR_BYTE, {3'b110, cp[10:6]}, s.nm, lstr, 1'b0);
                c = c + 3'd1;
                ev[c] = mk_ev(K_STR_BYTE, {2'b10, cp[5:0]}, s.nm, lstr, 1'b0);
                c = c + 3'd1;
            end else if (cp <= 21'hFFFF) begin
                ev[c] = mk_ev(K_STR_BYTE, {4'b1110, cp[15:12]}, s.nm, lstr, 1'b0);
                c = c + 3'd1;
                ev[c] = mk_ev(K_STR_BYTE, {2'b10, cp[11:6]}, s.nm, lstr, 1'b0);
                c = c + 3'd1;
                ev[c] = mk_ev(K_STR_BYTE, {2'b10, cp[5:0]}, s.nm, lstr, 1'b0);
                c = c + 3'd1;
            end else begin
                ev[c] = mk_ev(K_STR_BYTE, {5'b11110, cp[20:18]}, s.nm, lstr, 1'b0);
                c = c + 3'd1;
                ev[c] = mk_ev(K_STR_BYTE, {2'b10, cp[17:12]}, s.nm, lstr, 1'b0);
                c = c + 3'd1;
                ev[c] = mk_ev(K_STR_BYTE, {2'b10, cp[11:6]}, s.nm, lstr, 1'b0);
                c = c + 3'd1;
                ev[c] = mk_ev(K_STR_BYTE, {2'b10, cp[5:0]}, s.nm, lstr, 1'b0);
                c = c + 3'd1;
            end
        end

        // An error drops every event that the scan of this byte produced.
        if (s.failed) begin
            c = 3'd0;
        end

        if (i_final) begin
            if (!s.failed && (s.lex == LEX_NZERO || s.lex == LEX_NINT ||
                              s.lex == LEX_NFRAC || s.lex == LEX_NEXP)) begin
                ev[c] = mk_ev(K_NUM_END, 8'h00, 1'b0, s.nest, 1'b0);
                c = c + 3'd1;
                s.lex = LEX_AFTER;
            end
            vld = !s.failed && s.lex == LEX_AFTER && s.nest == 5'd0;
            ev[c] = mk_ev(K_DOC_END, 8'h00, 1'b0, 5'd0, vld);
            c = c + 3'd1;
            s = '0;
            s.lex = LEX_DOC;
        end

        o_st = s;
        o_ev = ev;
        o_cnt = c;
        o_wr = wr;
    end

endmodule

>>> sv/strict_json_stream_validator.sv
// ----------------------------------------------------------------------------
// strict_json_stream_validator: streaming strict JSON checker and tokenizer
// Takes a document one byte per item and emits token events with decoded
// string bytes, ending each document with a doc end event and its verdict.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one document byte per item
//   and a final mark on the last byte. Output channel (o_out_valid /
//   i_out_stall) carries one event per item; o_out_last marks the last event
//   caused by one input byte. The node limit is written through the cfg
//   channel, which is always ready and must only be used while the block idles.
//   Events reach the output through the event buffer and output register.
//   Throughput: one byte per cycle as long as each byte causes at most one
//   event and the receiver does not stall; a byte with more events holds
//   the input until the single output register takes its last event.
//   Bytes causing no event (whitespace, literal letters) never hold the input.
//   Reset (synchronous, active low) returns the scanner to document start,
//   empties the event buffer and sets the node limit to 4096.
//   When the receiver stalls, the output event holds and the input stalls as
//   soon as the buffered events of the last byte cannot move on.
// ----------------------------------------------------------------------------
module strict_json_stream_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_final,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_event_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_is_name,
    output logic [4:0]  o_level,
    output logic        o_doc_valid,
    output logic        o_out_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import sjv_pkg::*;

    // Scanner state and configuration.
    t_st         r_st;
    t_st         n_st;
    logic [15:0] r_limit;
    logic        r_stack [StackDepth];

    // Events of the most recent byte, drained one per cycle while the receiver does not stall.
    t_ev         r_q [MaxEv];
    t_ev         n_q [MaxEv];
    logic [2:0]  r_qcnt;
    logic [2:0]  n_qcnt;
    logic [2:0]  r_qrd;

    // Output register.
    logic        r_ov;
    t_ev         r_o;
    logic        r_olast;

    t_stk_wr     n_wr;
    logic        top_arr;
    logic        pend;
    logic        out_free;
    logic        move;
    logic        last_move;
    logic        in_acc;

    // The innermost open container; only read when at least one is open.
    assign top_arr = (r_st.nest == 5'd0) ? 1'b0 : r_stack[StackAw'(r_st.nest - 5'd1)];

    sjv_step u_step (
        .i_st      (r_st),
        .i_byte    (i_in_byte),
        .i_final   (i_in_final),
        .i_limit   (r_limit),
        .i_top_arr (top_arr),
        .o_st      (n_st),
        .o_ev      (n_q),
        .o_cnt     (n_qcnt),
        .o_wr      (n_wr)
    );

    assign pend = (r_qrd != r_qcnt);
    assign out_free = !r_ov || !i_out_stall;
    assign move = pend && out_free;
    assign last_move = move && ((r_qrd + 3'd1) == r_qcnt);
    // A new byte enters once the buffer is empty or gives up its last event now.
    assign o_in_stall = pend && !last_move;
    assign in_acc = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
            r_limit <= NodeLimitReset;
            r_qcnt <= 3'd0;
            r_qrd <= 3'd0;
            r_ov <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (in_acc) begin
                r_st <= n_st;
                r_qcnt <= n_qcnt;
                r_qrd <= 3'd0;
            end else if (move) begin
                r_qrd <= r_qrd + 3'd1;
            end
            if (move) begin
                r_ov <= 1'b1;
            end else if (out_free) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_q <= n_q;
            if (n_wr.en) begin
                r_stack[StackAw'(r_st.nest)] <= n_wr.arr;
            end
        end
        if (move) begin
            r_o <= r_q[r_qrd];
            r_olast <= ((r_qrd + 3'd1) == r_qcnt);
        end
    end

    assign o_out_valid = r_ov;
    assign o_event_kind = r_o.kind;
    assign o_out_byte = r_o.data;
    assign o_is_name = r_o.nm;
    assign o_level = r_o.lvl;
    assign o_doc_valid = r_o.ok;
    assign o_out_last = r_olast;

`ifndef NO_ASSERTIONS
    a_rd_le_cnt : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qrd <= r_qcnt)
        else $error("event buffer read index passed its count");

    a_cnt_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= 3'(MaxEv))
        else $error("event buffer count beyond capacity");

    a_doc_end_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_kind == K_DOC_END) |-> o_out_last)
        else $error("doc end event is not the last event of its byte");

    a_nest_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.nest <= 5'(StackDepth))
        else $error("nesting level beyond stack depth");

    a_final_resets : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_final) |=> (r_st.nest == 5'd0 && !r_st.failed))
        else $error("scanner state not cleared after document end");
`endif

endmodule

>>> verif/tb_strict_json_stream_validator.sv
// ----------------------------------------------------------------------------
// tb_strict_json_stream_validator: self-checking bench of the JSON validator
// Feeds documents byte by byte, predicts every token event in the bench and
// compares each event item, field by field, under several idling phases.
// ----------------------------------------------------------------------------
module tb_strict_json_stream_validator;
    import sjv_pkg::*;

    // Predictor scanner states, kept apart from the block's own encoding.
    typedef enum int {
        P_DOC, P_ARR_FIRST, P_ELEM, P_MEMBER, P_KEY_FIRST, P_KEY_NEXT, P_COLON,
        P_AFTER, P_STR, P_ESC, P_HEX, P_SBS, P_SU, P_HEXL,
        P_NSTR, P_NESC, P_NHEX, P_NSBS, P_NSU, P_NHEXL,
        P_TRUE, P_FALSE, P_NULL,
        P_NSIGN, P_NZERO, P_NINT, P_NDOT, P_NFRAC, P_NE, P_NESIGN, P_NEXP
    } t_scan;

    // Idling phases of the two channels.
    typedef enum int {
        PH_NONE, PH_SEND, PH_RECV, PH_BOTH
    } t_phase;

    localparam int NameOfs = 6;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_in_byte;
    logic        i_in_final;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [3:0]  o_event_kind;
    logic [7:0]  o_out_byte;
    logic        o_is_name;
    logic [4:0]  o_level;
    logic        o_doc_valid;
    logic        o_out_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    strict_json_stream_validator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_in_byte(i_in_byte), .i_in_final(i_in_final),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_event_kind(o_event_kind), .o_out_byte(o_out_byte),
        .o_is_name(o_is_name), .o_level(o_level),
        .o_doc_valid(o_doc_valid), .o_out_last(o_out_last),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    // A token event together with its last mark, as the output port shows it.
    typedef struct {
        t_kind      kind;
        logic [7:0] data;
        logic       nm;
        logic [4:0] lvl;
        logic       ok;
        logic       last;
    } t_token;

    // One directed row: a byte, its final mark, and optionally the single
    // event that it must cause.
    typedef struct {
        logic [7:0] b;
        logic       fin;
        logic       has_exp;
        t_kind      kind;
        logic       ok;
    } t_row;

    t_token     token_fifo[$];
    t_token     byte_events[$];
    int         errors = 0;
    t_phase     phase = PH_NONE;

    // Shadow of the block's state.
    logic [15:0] sh_node_limit;
    logic        sh_stack[MaxDepth + 1];
    int          sh_nest;
    int          sh_nodes;
    t_scan       sh_scan;
    logic [15:0] sh_hex;
    logic [9:0]  sh_hs;
    int          sh_lpos;
    logic        sh_failed;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    initial begin
        #50000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic bit is_ws(logic [7:0] b);
        return b == " " || b == 8'h09 || b == 8'h0d || b == 8'h0a;
    endfunction

    function automatic bit is_dig(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic int nib_of(logic [7:0] b);
        if (is_dig(b)) return b - "0";
        if (b >= "a" && b <= "f") return b - "a" + 10;
        if (b >= "A" && b <= "F") return b - "A" + 10;
        return 16;
    endfunction

    // Records one event of the current byte; at most five fit.
    task automatic push_event(t_kind k, logic [7:0] d, logic nm, int lvl, logic ok);
        t_token t;
        if (byte_events.size() < MaxEv) begin
            t.kind = k;
            t.data = d;
            t.nm = nm;
            t.lvl = lvl[4:0];
            t.ok = ok;
            t.last = 1'b0;
            byte_events = {byte_events, t};
        end
    endtask

    task automatic push_utf8(int cp, logic nm, int lvl);
        if (cp <= 'h7f) begin
            push_event(K_STR_BYTE, cp[7:0], nm, lvl, 0);
        end else if (cp <= 'h7ff) begin
            push_event(K_STR_BYTE, 8'('hc0 | (cp >> 6)), nm, lvl, 0);
            push_event(K_STR_BYTE, 8'('h80 | (cp & 'h3f)), nm, lvl, 0);
        end else if (cp <= 'hffff) begin
            push_event(K_STR_BYTE, 8'('he0 | (cp >> 12)), nm, lvl, 0);
            push_event(K_STR_BYTE, 8'('h80 | ((cp >> 6) & 'h3f)), nm, lvl, 0);
            push_event(K_STR_BYTE, 8'('h80 | (cp & 'h3f)), nm, lvl, 0);
        end else begin
            push_event(K_STR_BYTE, 8'('hf0 | ((cp >> 18) & 7)), nm, lvl, 0);
            push_event(K_STR_BYTE, 8'('h80 | ((cp >> 12) & 'h3f)), nm, lvl, 0);
            push_event(K_STR_BYTE, 8'('h80 | ((cp >> 6) & 'h3f)), nm, lvl, 0);
            push_event(K_STR_BYTE, 8'('h80 | (cp & 'h3f)), nm, lvl, 0);
        end
    endtask

    task automatic clear_doc();
        for (int i = 0; i <= MaxDepth; i++) sh_stack[i] = 1'b0;
        sh_nest = 0;
        sh_nodes = 0;
        sh_scan = P_DOC;
        sh_hex = '0;
        sh_hs = '0;
        sh_lpos = 0;
        sh_failed = 1'b0;
    endtask

    task automatic close_cont(t_kind k);
        sh_nest--;
        push_event(k, 0, 0, sh_nest, 0);
        sh_scan = P_AFTER;
    endtask

    task automatic begin_value(logic [7:0] b);
        bit arr;
        if (sh_nest > MaxDepth || sh_nodes >= sh_node_limit) begin
            sh_failed = 1'b1;
            return;
        end
        sh_nodes++;
        if (b == "{" || b == "[") begin
            arr = (b == "[");
            sh_stack[sh_nest] = arr;
            push_event(arr ? K_ARR_OPEN : K_OBJ_OPEN, 0, 0, sh_nest, 0);
            sh_nest++;
            sh_scan = arr ? P_ARR_FIRST : P_KEY_FIRST;
        end else if (b == "\"") begin
            push_event(K_STR_OPEN, 0, 0, sh_nest, 0);
            sh_scan = P_STR;
        end else if (b == "t" || b == "f" || b == "n") begin
            sh_lpos = 1;
            sh_scan = (b == "t") ? P_TRUE : (b == "f") ? P_FALSE : P_NULL;
        end else if (b == "-" || is_dig(b)) begin
            push_event(K_NUM_CHAR, b, 0, sh_nest, 0);
            sh_scan = (b == "-") ? P_NSIGN : (b == "0") ? P_NZERO : P_NINT;
        end else begin
            sh_failed = 1'b1;
        end
    endtask

    // String states; member names run in a copy of the states offset by six.
    task automatic string_char(logic [7:0] b);
        logic nm;
        int   off, s, lvl, nb, cp;
        nm = (sh_scan >= P_NSTR && sh_scan <= P_NHEXL);
        off = nm ? NameOfs : 0;
        s = int'(sh_scan) - off;
        lvl = nm ? (sh_nest ? sh_nest - 1 : 0) : sh_nest;
        case (s)
            P_STR: begin
                if (b == "\"") begin
                    push_event(K_STR_CLOSE, 0, nm, lvl, 0);
                    sh_scan = nm ? P_COLON : P_AFTER;
                end else if (b < 8'h20) begin
                    sh_failed = 1'b1;
                end else if (b == "\\") begin
                    sh_scan = t_scan'(P_ESC + off);
                end else begin
                    push_event(K_STR_BYTE, b, nm, lvl, 0);
                end
            end
            P_ESC: begin
                cp = -1;
                case (b)
                    "\"", "\\", "/": cp = b;
                    "b": cp = 8'h08;
                    "f": cp = 8'h0c;
                    "n": cp = 8'h0a;
                    "r": cp = 8'h0d;
                    "t": cp = 8'h09;
                    "u": cp = 'h100;
                    default: sh_failed = 1'b1;
                endcase
                if (cp == 'h100) begin
                    sh_hex = 0;
                    sh_lpos = 0;
                    sh_scan = t_scan'(P_HEX + off);
                end else if (cp >= 0) begin
                    push_event(K_STR_BYTE, cp[7:0], nm, lvl, 0);
                    sh_scan = t_scan'(P_STR + off);
                end
            end
            P_HEX, P_HEXL: begin
                nb = nib_of(b);
                if (nb > 15) begin
                    sh_failed = 1'b1;
                    return;
                end
                sh_hex = {sh_hex[11:0], nb[3:0]};
                if (sh_lpos < 3) begin
                    sh_lpos++;
                    return;
                end
                sh_lpos = 0;
                cp = sh_hex;
                if (s == P_HEX) begin
                    if (cp >= 'hd800 && cp <= 'hdbff) begin
                        sh_hs = 10'(cp - 'hd800);
                        sh_scan = t_scan'(P_SBS + off);
                    end else if (cp >= 'hdc00 && cp <= 'hdfff) begin
                        sh_failed = 1'b1;
                    end else begin
                        push_utf8(cp, nm, lvl);
                        sh_scan = t_scan'(P_STR + off);
                    end
                end else begin
                    if (cp < 'hdc00 || cp > 'hdfff) begin
                        sh_failed = 1'b1;
                        return;
                    end
                    push_utf8('h10000 + (int'(sh_hs) << 10) + (cp - 'hdc00), nm, lvl);
                    sh_scan = t_scan'(P_STR + off);
                end
            end
            P_SBS: begin
                if (b == "\\") sh_scan = t_scan'(P_SU + off);
                else sh_failed = 1'b1;
            end
            P_SU: begin
                if (b == "u") begin
                    sh_hex = 0;
                    sh_lpos = 0;
                    sh_scan = t_scan'(P_HEXL + off);
                end else begin
                    sh_failed = 1'b1;
                end
            end
            default: sh_failed = 1'b1;
        endcase
    endtask

    // Sets again when the number ended and the byte must be scanned again.
    task automatic number_char(input logic [7:0] b, output bit again);
        bit    dg, ex, stop;
        t_scan nx;
        again = 1'b0;
        dg = is_dig(b);
        ex = (b == "e" || b == "E");
        stop = 1'b0;
        nx = P_NEXP;
        case (sh_scan)
            P_NSIGN: begin
                if (!dg) begin
                    sh_failed = 1'b1;
                    return;
                end
                nx = (b == "0") ? P_NZERO : P_NINT;
            end
            P_NZERO: begin
                if (dg) begin
                    sh_failed = 1'b1;
                    return;
                end
                if (b == ".") nx = P_NDOT; else if (ex) nx = P_NE; else stop = 1'b1;
            end
            P_NINT: begin
                if (dg) nx = P_NINT; else if (b == ".") nx = P_NDOT;
                else if (ex) nx = P_NE; else stop = 1'b1;
            end
            P_NDOT: begin
                if (!dg) begin
                    sh_failed = 1'b1;
                    return;
                end
                nx = P_NFRAC;
            end
            P_NFRAC: begin
                if (dg) nx = P_NFRAC; else if (ex) nx = P_NE; else stop = 1'b1;
            end
            P_NE: begin
                if (b == "+" || b == "-") begin
                    nx = P_NESIGN;
                end else if (dg) begin
                    nx = P_NEXP;
                end else begin
                    sh_failed = 1'b1;
                    return;
                end
            end
            P_NESIGN: begin
                if (!dg) begin
                    sh_failed = 1'b1;
                    return;
                end
                nx = P_NEXP;
            end
            default: begin
                if (!dg) stop = 1'b1;
            end
        endcase
        if (stop) begin
            push_event(K_NUM_END, 0, 0, sh_nest, 0);
            sh_scan = P_AFTER;
            again = 1'b1;
            return;
        end
        push_event(K_NUM_CHAR, b, 0, sh_nest, 0);
        sh_scan = nx;
    endtask

    function automatic logic [7:0] lit_letter(t_scan w, int pos);
        string txt;
        txt = (w == P_TRUE) ? "true" : (w == P_FALSE) ? "false" : "null";
        return (pos < txt.len()) ? txt[pos] : 8'h00;
    endfunction

    task automatic scan_byte(logic [7:0] b);
        bit    again;
        int    llen;
        t_kind lk;
        again = 1'b1;
        while (again && !sh_failed) begin
            again = 1'b0;
            if (sh_scan <= P_MEMBER) begin
                if (is_ws(b)) continue;
                if (sh_scan == P_ARR_FIRST && b == "]") close_cont(K_ARR_CLOSE);
                else begin_value(b);
            end else if (sh_scan == P_KEY_FIRST || sh_scan == P_KEY_NEXT) begin
                if (is_ws(b)) continue;
                if (sh_scan == P_KEY_FIRST && b == "}") begin
                    close_cont(K_OBJ_CLOSE);
                end else if (b == "\"") begin
                    push_event(K_STR_OPEN, 0, 1, sh_nest ? sh_nest - 1 : 0, 0);
                    sh_scan = P_NSTR;
                end else begin
                    sh_failed = 1'b1;
                end
            end else if (sh_scan == P_COLON) begin
                if (is_ws(b)) continue;
                if (b == ":") sh_scan = P_MEMBER; else sh_failed = 1'b1;
            end else if (sh_scan == P_AFTER) begin
                if (is_ws(b)) continue;
                if (sh_nest == 0) begin
                    sh_failed = 1'b1;
                end else if (sh_stack[sh_nest - 1]) begin
                    if (b == "]") close_cont(K_ARR_CLOSE);
                    else if (b == ",") sh_scan = P_ELEM;
                    else sh_failed = 1'b1;
                end else begin
                    if (b == "}") close_cont(K_OBJ_CLOSE);
                    else if (b == ",") sh_scan = P_KEY_NEXT;
                    else sh_failed = 1'b1;
                end
            end else if (sh_scan >= P_STR && sh_scan <= P_NHEXL) begin
                string_char(b);
            end else if (sh_scan >= P_TRUE && sh_scan <= P_NULL) begin
                llen = (sh_scan == P_FALSE) ? 5 : 4;
                if (sh_lpos >= llen || b != lit_letter(sh_scan, sh_lpos)) begin
                    sh_failed = 1'b1;
                    continue;
                end
                sh_lpos++;
                if (sh_lpos == llen) begin
                    lk = (sh_scan == P_TRUE) ? K_TRUE : (sh_scan == P_FALSE) ? K_FALSE
                                                                                : K_NULL;
                    sh_lpos = 0;
                    push_event(lk, 0, 0, sh_nest, 0);
                    sh_scan = P_AFTER;
                end
            end else begin
                number_char(b, again);
            end
        end
    endtask

    // Predicts the events of one accepted byte and queues them.
    task automatic predict_byte(logic [7:0] b, logic fin);
        logic ok;
        byte_events.delete();
        if (!sh_failed) begin
            scan_byte(b);
            if (sh_failed) byte_events.delete();
        end
        if (fin) begin
            if (!sh_failed && (sh_scan == P_NZERO || sh_scan == P_NINT ||
                               sh_scan == P_NFRAC || sh_scan == P_NEXP)) begin
                push_event(K_NUM_END, 0, 0, sh_nest, 0);
                sh_scan = P_AFTER;
            end
            ok = !sh_failed && sh_scan == P_AFTER && sh_nest == 0;
            push_event(K_DOC_END, 0, 0, 0, ok);
            clear_doc();
        end
        if (byte_events.size() > 0) byte_events[byte_events.size() - 1].last = 1'b1;
        foreach (byte_events[i]) token_fifo = {token_fifo, byte_events[i]};
    endtask

    // Output side: stall at random by phase and check each accepted event.
    always @(posedge i_clk) begin
        t_token exp_tok;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (token_fifo.size() == 0) begin
                $error("unexpected event item kind %0d", o_event_kind);
                errors++;
            end else begin
                exp_tok = token_fifo.pop_front();
                if (o_event_kind !== exp_tok.kind) begin
                    $error("event_kind expected %0d actual %0d", exp_tok.kind, o_event_kind);
                    errors++;
                end
                if (o_out_byte !== exp_tok.data) begin
                    $error("out_byte expected %0h actual %0h", exp_tok.data, o_out_byte);
                    errors++;
                end
                if (o_is_name !== exp_tok.nm) begin
                    $error("is_name expected %0b actual %0b", exp_tok.nm, o_is_name);
                    errors++;
                end
                if (o_level !== exp_tok.lvl) begin
                    $error("level expected %0d actual %0d", exp_tok.lvl, o_level);
                    errors++;
                end
                if (o_doc_valid !== exp_tok.ok) begin
                    $error("doc_valid expected %0b actual %0b", exp_tok.ok, o_doc_valid);
                    errors++;
                end
                if (o_out_last !== exp_tok.last) begin
                    $error("out_last expected %0b actual %0b", exp_tok.last, o_out_last);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (phase == PH_RECV || phase == PH_BOTH) begin
            i_out_stall <= ($urandom_range(99) < ((phase == PH_RECV) ? 60 : 10));
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Sends one byte: optional idle cycles, then hold valid until accepted.
    task automatic send_byte(logic [7:0] b, logic fin);
        int pct;
        pct = (phase == PH_SEND) ? 60 : (phase == PH_BOTH) ? 10 : 0;
        while ($urandom_range(99) < pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_byte = b;
        i_in_final = fin;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_byte(b, fin);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic send_text(string s, logic fin_on_last);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], fin_on_last && (i == s.len() - 1));
        end
    endtask

    // Waits for every expected event, then idles before the next step.
    task automatic drain();
        while (token_fifo.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [15:0] v);
        i_cfg_valid = 1'b1;
        i_cfg_data = v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sh_node_limit = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Random snippets: mostly well-formed pieces with random content.
    function automatic string rand_scalar();
        string s;
        int    n;
        case ($urandom_range(9))
            0: return "true";
            1: return "false";
            2: return "null";
            3: begin
                s = ($urandom_range(1)) ? "-" : "";
                s = {s, $sformatf("%0d", $urandom_range(9999))};
                if ($urandom_range(1)) s = {s, ".", $sformatf("%0d", $urandom_range(99))};
                if ($urandom_range(1)) s = {s, ($urandom_range(1) ? "e-" : "E+"), "7"};
                return s;
            end
            4: return {"\"\\u", $sformatf("%04x", $urandom_range(16'hd7ff)), "\""};
            5: return "\"\\ud83d\\ude00\"";
            6: return "\"\\\"\\\\\\/\\b\\f\\n\\r\\t\"";
            default: begin
                s = "\"";
                n = $urandom_range(4);
                for (int i = 0; i < n; i++) begin
                    s = {s, string'(byte'($urandom_range(8'h23, 8'h5b)))};
                end
                return {s, "\""};
            end
        endcase
    endfunction

    // Containers hold scalars only, which keeps the documents short.
    function automatic string rand_value(int depth);
        string s;
        int    n;
        if (depth > 0 || $urandom_range(2) == 0) return rand_scalar();
        n = $urandom_range(2);
        if ($urandom_range(1)) begin
            s = "[";
            for (int i = 0; i < n; i++) begin
                s = {s, (i ? ", " : ""), rand_value(depth + 1)};
            end
            return {s, "]"};
        end
        s = "{";
        for (int i = 0; i < n; i++) begin
            s = {s, (i ? "," : ""), "\"k", $sformatf("%0d", i), "\":", rand_value(depth + 1)};
        end
        return {s, "}"};
    endfunction

    t_row rows[$];

    task automatic add_row(logic [7:0] b, logic fin, logic has, t_kind k, logic ok);
        t_row r;
        r.b = b;
        r.fin = fin;
        r.has_exp = has;
        r.kind = k;
        r.ok = ok;
        rows = {rows, r};
    endtask

    initial begin
        string doc;
        int    n_items;
        t_token top;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_byte = 8'h00;
        i_in_final = 1'b0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 16'h0000;
        sh_node_limit = NodeLimitReset;
        clear_doc();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table. A lone final byte right after reset ends an empty
        // document, and bytes 0x00 and 0xFF as values are errors; those rows
        // carry their single doc end item typed in.
        add_row(8'h20, 1, 1, K_DOC_END, 0);
        add_row(8'h00, 1, 1, K_DOC_END, 0);
        add_row(8'hff, 1, 1, K_DOC_END, 0);
        add_row("7", 0, 0, K_NUM_CHAR, 0);
        add_row("0", 1, 0, K_DOC_END, 0);
        add_row("0", 0, 0, K_NUM_CHAR, 0);
        add_row("1", 1, 0, K_DOC_END, 0);
        add_row("[", 0, 0, K_ARR_OPEN, 0);
        add_row("1", 0, 0, K_NUM_CHAR, 0);
        add_row(",", 0, 0, K_NUM_CHAR, 0);
        add_row("]", 1, 0, K_DOC_END, 0);
        add_row("\"", 0, 0, K_STR_OPEN, 0);
        add_row(8'h1f, 0, 0, K_STR_OPEN, 0);
        add_row("\"", 1, 0, K_DOC_END, 0);
        foreach (rows[i]) begin
            send_byte(rows[i].b, rows[i].fin);
            if (rows[i].has_exp) begin
                top = token_fifo[token_fifo.size() - 1];
                if (top.kind != rows[i].kind || top.ok != rows[i].ok) begin
                    $error("directed row %0d predicted kind %0d", i, top.kind);
                    errors++;
                end
            end
        end
        // Special cases: escapes, pairs, bad escapes, nesting, trailing content.
        send_text("{\"a\":[tru", 0);
        send_byte("e", 1);
        send_text("\"\\u00e9\\ud83d\\ude00\\u0000\"", 1);
        send_text("\"\\ude00\"", 1);
        send_text("\"\\ud800x\"", 1);
        send_text("\"\\q\"", 1);
        send_text("[[[[[[[[[[[[[[[[[1", 1);
        send_text("1 x", 1);
        send_text("-1.5e+3", 1);
        send_text("{\"k\":1,\"k\":2}", 1);
        send_text("\"\x80\xff\"", 1);
        drain();

        // Node limit extremes: one, largest, zero, and back to a small one.
        write_limit(16'd1);
        send_text("[1]", 1);
        send_text("7", 1);
        drain();
        write_limit(16'hffff);
        send_text("[1]", 1);
        drain();
        write_limit(16'd0);
        send_text("1", 1);
        drain();
        write_limit(16'd3);
        send_text("[1,2]", 1);
        send_text("[1,2,3]", 1);
        drain();

        // Random part, phase by phase; each phase has its own node limit.
        n_items = 0;
        for (int p = 0; p < 4; p++) begin
            phase = t_phase'(p);
            write_limit((p == 3) ? 16'd6 : 16'(NodeLimitReset + p));
            repeat (2) begin
                doc = (p == 1 && $urandom_range(3) == 0) ? rand_scalar() : rand_value(0);
                if ($urandom_range(9) == 0) begin
                    // Broken document: one byte replaced by noise.
                    doc[$urandom_range(doc.len() - 1)] = byte'($urandom_range(255));
                end
                if ($urandom_range(9) == 0) begin
                    // Truncated document.
                    doc = doc.substr(0, $urandom_range(doc.len() - 1));
                end
                if ($urandom_range(1)) doc = {" ", doc, "\n"};
                send_text(doc, 1);
                n_items += doc.len();
                // Sender holds off until every expected event is out.
                if (p == 2 && n_items > 0) while (token_fifo.size() != 0) @(negedge i_clk);
            end
            drain();
        end
        // Pure noise bytes with random final marks, then one closing document.
        phase = PH_BOTH;
        repeat (8) send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
        send_byte("1", 1);
        drain();
        phase = PH_NONE;

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
